// File: src/ehash_pkg.sv
// Shared constants and types for the extendible hash table engine.
package ehash_pkg;

  localparam int MAX_DEPTH   = 8;
  localparam int DIR_BITS    = MAX_DEPTH;
  localparam int SLOT_BITS   = 2;
  localparam int SLOTS       = 1 << SLOT_BITS;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int DEPTH_W     = 4;
  localparam int CNT_W       = DIR_BITS + 1;
  localparam int CAP_W       = 3;
  localparam int TRY_W       = 5;
  localparam int MAX_TRIES   = 2 * MAX_DEPTH + 4;

  localparam logic [1:0] OP_FIND   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  typedef struct packed {
    logic [DEPTH_W-1:0] ld;
    logic [SLOTS-1:0]   valid;
  } meta_t;

  typedef struct packed {
    logic                          dir_we;
    logic [DIR_BITS-1:0]           dir_waddr;
    logic [DIR_BITS-1:0]           dir_wdata;
    logic [DIR_BITS-1:0]           dir_raddr;
    logic                          meta_we;
    logic [DIR_BITS-1:0]           meta_waddr;
    meta_t                         meta_wdata;
    logic [DIR_BITS-1:0]           meta_raddr;
    logic                          slot_we;
    logic [DIR_BITS+SLOT_BITS-1:0] slot_waddr;
    logic [KEY_W-1:0]              slot_wkey;
    logic [VAL_W-1:0]              slot_wval;
    logic [DIR_BITS+SLOT_BITS-1:0] slot_raddr;
  } mem_req_t;

  typedef struct packed {
    logic [DIR_BITS-1:0] dir_rdata;
    meta_t               meta_rdata;
    logic [KEY_W-1:0]    key_rdata;
    logic [VAL_W-1:0]    val_rdata;
  } mem_rsp_t;

endpackage

// File: src/ehash_store.sv
// Directory, bucket metadata and slot memories with registered reads.
module ehash_store import ehash_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  logic [DIR_BITS-1:0] dir_mem  [1 << DIR_BITS];
  meta_t               meta_mem [1 << DIR_BITS];
  logic [KEY_W-1:0]    key_mem  [1 << (DIR_BITS + SLOT_BITS)];
  logic [VAL_W-1:0]    val_mem  [1 << (DIR_BITS + SLOT_BITS)];

  always_ff @(posedge clk) begin
    if (req.dir_we) begin
      dir_mem[req.dir_waddr] <= req.dir_wdata;
    end
    if (req.meta_we) begin
      meta_mem[req.meta_waddr] <= req.meta_wdata;
    end
    if (req.slot_we) begin
      key_mem[req.slot_waddr] <= req.slot_wkey;
      val_mem[req.slot_waddr] <= req.slot_wval;
    end
    rsp.dir_rdata  <= dir_mem[req.dir_raddr];
    rsp.meta_rdata <= meta_mem[req.meta_raddr];
    rsp.key_rdata  <= key_mem[req.slot_raddr];
    rsp.val_rdata  <= val_mem[req.slot_raddr];
  end

endmodule

// File: src/extendible_hash_table_unit.sv
// Extendible hash table engine: sequencer over shared table memories.
// Busy stays high from the accepting edge of an operation until it completes; the done beat
// follows. A split doubles the directory when needed (a read and a write per old entry),
// re-points directory entries (a read and a write per entry), moves slots (a read and a
// conditional write per slot) and writes both metadata rows, then the insert retries from the lookup.
// A new start is taken at the edge that ends the done beat. Reset is synchronous and
// empties the table; results cannot be stalled.
module extendible_hash_table_unit import ehash_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic [KEY_W-1:0]   key,
  input  logic [VAL_W-1:0]   value,
  input  logic               bucket_capacity_we,
  input  logic [CAP_W-1:0]   bucket_capacity,
  output logic               done,
  output logic               found,
  output logic [VAL_W-1:0]   read_value,
  output logic               status,
  output logic [DEPTH_W-1:0] key_local_depth,
  output logic [DEPTH_W-1:0] current_global_depth,
  output logic [CNT_W-1:0]   bucket_count
);

  typedef enum logic [4:0] {
    S_IDLE, S_DIR, S_META, S_MREG, S_RDK, S_CMPK, S_DECIDE, S_VAL, S_SPLIT,
    S_CPR, S_CPW, S_ALLOC, S_RDR, S_RDRW, S_MVR, S_MVW, S_MW0, S_MW1
  } state_t;

  state_t                 state;
  logic [1:0]             op_r;
  logic [KEY_W-1:0]       key_r;
  logic [VAL_W-1:0]       val_r;
  logic [CAP_W-1:0]       cap;
  logic [DEPTH_W-1:0]     gd;
  logic [CNT_W-1:0]       used;
  logic [DIR_BITS-1:0]    b;
  logic [DIR_BITS-1:0]    nb;
  logic [DEPTH_W-1:0]     ld;
  logic [SLOTS-1:0]       vmask;
  logic [SLOTS-1:0]       nv;
  logic [SLOT_BITS-1:0]   s;
  logic [SLOT_BITS-1:0]   dst;
  logic [SLOT_BITS-1:0]   hit_slot;
  logic                   hit;
  logic [CNT_W-1:0]       i;
  logic [TRY_W-1:0]       tries;
  logic                   fin;
  logic                   row0_w;
  logic                   res_found;
  logic [VAL_W-1:0]       res_val;
  logic                   res_status;

  mem_req_t               req;
  mem_rsp_t               rsp;

  logic [DIR_BITS-1:0]    idx;
  logic [DIR_BITS-1:0]    bsel;
  logic [DIR_BITS-1:0]    dir_d;
  logic [CNT_W-1:0]       n;
  logic [CAP_W-1:0]       cap_eff;
  logic [CAP_W-1:0]       cnt;
  logic [SLOT_BITS-1:0]   free_slot;
  logic                   meta_zero;

  ehash_store u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  assign n         = CNT_W'(1) << gd;
  assign idx       = key_r[DIR_BITS-1:0] & DIR_BITS'(n - CNT_W'(1));
  assign bsel      = (idx == '0) ? '0 : rsp.dir_rdata;
  assign dir_d     = (i == '0) ? '0 : rsp.dir_rdata;
  assign meta_zero = ({1'b0, b} >= used) || (b == '0 && !row0_w);
  assign cap_eff   = (cap == '0) ? CAP_W'(1) : (cap > CAP_W'(SLOTS)) ? CAP_W'(SLOTS) : cap;
  assign cnt       = CAP_W'($countones(vmask));
  assign busy      = (state != S_IDLE);

  always_comb begin
    free_slot = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!vmask[k]) begin
        free_slot = SLOT_BITS'(k);
      end
    end
  end

  always_comb begin
    req = '0;
    req.dir_raddr  = idx;
    req.meta_raddr = bsel;
    req.slot_raddr = {b, s};
    unique case (state)
      S_CPR, S_RDR: begin
        req.dir_raddr = i[DIR_BITS-1:0];
      end
      S_CPW: begin
        req.dir_we    = 1'b1;
        req.dir_waddr = DIR_BITS'(n + i);
        req.dir_wdata = dir_d;
      end
      S_RDRW: begin
        req.dir_we    = (dir_d == b) && i[ld];
        req.dir_waddr = i[DIR_BITS-1:0];
        req.dir_wdata = nb;
      end
      S_DECIDE: begin
        req.slot_raddr = {b, hit_slot};
        if (op_r == OP_REMOVE && hit) begin
          req.meta_we    = 1'b1;
          req.meta_waddr = b;
          req.meta_wdata = '{ld: ld, valid: vmask & ~(SLOTS'(1) << hit_slot)};
        end else if (op_r == OP_INSERT && hit) begin
          req.slot_we    = 1'b1;
          req.slot_waddr = {b, hit_slot};
          req.slot_wkey  = key_r;
          req.slot_wval  = val_r;
        end else if (op_r == OP_INSERT && cnt < cap_eff && vmask != '1) begin
          req.slot_we    = 1'b1;
          req.slot_waddr = {b, free_slot};
          req.slot_wkey  = key_r;
          req.slot_wval  = val_r;
          req.meta_we    = 1'b1;
          req.meta_waddr = b;
          req.meta_wdata = '{ld: ld, valid: vmask | (SLOTS'(1) << free_slot)};
        end
      end
      S_MVW: begin
        req.slot_we    = rsp.key_rdata[ld];
        req.slot_waddr = {nb, dst};
        req.slot_wkey  = rsp.key_rdata;
        req.slot_wval  = rsp.val_rdata;
      end
      S_MW0: begin
        req.meta_we    = 1'b1;
        req.meta_waddr = b;
        req.meta_wdata = '{ld: ld + DEPTH_W'(1), valid: vmask};
      end
      S_MW1: begin
        req.meta_we    = 1'b1;
        req.meta_waddr = nb;
        req.meta_wdata = '{ld: ld + DEPTH_W'(1), valid: nv};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cap    <= CAP_W'(SLOTS);
      gd     <= '0;
      used   <= CNT_W'(1);
      row0_w <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (bucket_capacity_we) begin
        cap <= bucket_capacity;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_r       <= op;
            key_r      <= key;
            val_r      <= value;
            tries      <= '0;
            fin        <= 1'b0;
            res_found  <= 1'b0;
            res_val    <= '0;
            res_status <= 1'b0;
            state      <= S_DIR;
          end
        end
        S_DIR: begin
          state <= S_META;
        end
        S_META: begin
          b     <= bsel;
          state <= S_MREG;
        end
        S_MREG: begin
          ld    <= meta_zero ? '0 : rsp.meta_rdata.ld;
          vmask <= meta_zero ? '0 : rsp.meta_rdata.valid;
          s     <= '0;
          hit   <= 1'b0;
          if (fin) begin
            done                 <= 1'b1;
            found                <= res_found;
            read_value           <= res_val;
            status               <= res_status;
            key_local_depth      <= meta_zero ? '0 : rsp.meta_rdata.ld;
            current_global_depth <= gd;
            bucket_count         <= used;
            state                <= S_IDLE;
          end else begin
            state <= S_RDK;
          end
        end
        S_RDK: begin
          state <= S_CMPK;
        end
        S_CMPK: begin
          if (vmask[s] && rsp.key_rdata == key_r) begin
            hit      <= 1'b1;
            hit_slot <= s;
            state    <= S_DECIDE;
          end else if (s == SLOT_BITS'(SLOTS - 1)) begin
            state <= S_DECIDE;
          end else begin
            s     <= s + SLOT_BITS'(1);
            state <= S_RDK;
          end
        end
        S_DECIDE: begin
          fin   <= 1'b1;
          state <= S_DIR;
          if (op_r == OP_FIND && hit) begin
            res_found <= 1'b1;
            state     <= S_VAL;
          end else if (op_r == OP_REMOVE && hit) begin
            res_found <= 1'b1;
            if (b == '0) begin
              row0_w <= 1'b1;
            end
          end else if (op_r == OP_INSERT && !hit && !(cnt < cap_eff && vmask != '1)) begin
            fin   <= 1'b0;
            state <= S_SPLIT;
          end else if (op_r == OP_INSERT && !hit && b == '0) begin
            row0_w <= 1'b1;
          end
        end
        S_VAL: begin
          res_val <= rsp.val_rdata;
          state   <= S_DIR;
        end
        S_SPLIT: begin
          i <= '0;
          if (ld >= gd) begin
            if (gd >= DEPTH_W'(MAX_DEPTH)) begin
              res_status <= 1'b1;
              fin        <= 1'b1;
              state      <= S_DIR;
            end else begin
              state <= S_CPR;
            end
          end else begin
            state <= S_ALLOC;
          end
        end
        S_CPR: begin
          state <= S_CPW;
        end
        S_CPW: begin
          i <= i + CNT_W'(1);
          if (i + CNT_W'(1) == n) begin
            gd    <= gd + DEPTH_W'(1);
            state <= S_ALLOC;
          end else begin
            state <= S_CPR;
          end
        end
        S_ALLOC: begin
          i <= '0;
          if (used >= CNT_W'(1 << DIR_BITS)) begin
            res_status <= 1'b1;
            fin        <= 1'b1;
            state      <= S_DIR;
          end else begin
            nb    <= used[DIR_BITS-1:0];
            used  <= used + CNT_W'(1);
            state <= S_RDR;
          end
        end
        S_RDR: begin
          state <= S_RDRW;
        end
        S_RDRW: begin
          i <= i + CNT_W'(1);
          if (i + CNT_W'(1) == n) begin
            s     <= '0;
            dst   <= '0;
            nv    <= '0;
            state <= S_MVR;
          end else begin
            state <= S_RDR;
          end
        end
        S_MVR: begin
          if (vmask[s]) begin
            state <= S_MVW;
          end else if (s == SLOT_BITS'(SLOTS - 1)) begin
            state <= S_MW0;
          end else begin
            s <= s + SLOT_BITS'(1);
          end
        end
        S_MVW: begin
          if (rsp.key_rdata[ld]) begin
            nv[dst]  <= 1'b1;
            vmask[s] <= 1'b0;
            dst      <= dst + SLOT_BITS'(1);
          end
          if (s == SLOT_BITS'(SLOTS - 1)) begin
            state <= S_MW0;
          end else begin
            s     <= s + SLOT_BITS'(1);
            state <= S_MVR;
          end
        end
        S_MW0: begin
          if (b == '0) begin
            row0_w <= 1'b1;
          end
          state <= S_MW1;
        end
        S_MW1: begin
          tries <= tries + TRY_W'(1);
          state <= S_DIR;
          if (tries + TRY_W'(1) == TRY_W'(MAX_TRIES)) begin
            res_status <= 1'b1;
            fin        <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the extendible hash table engine.
`timescale 1ns / 100ps

typedef struct {
  logic                found;
  logic [31:0]         read_value;
  logic                status;
  logic [3:0]          key_local_depth;
  logic [3:0]          current_global_depth;
  logic [8:0]          bucket_count;
} outcome_t;

class hash_table_scoreboard;
  bit [7:0]  dir_map [256];
  bit [31:0] slot_key [1024];
  bit [31:0] slot_val [1024];
  bit        slot_used [1024];
  bit [3:0]  bucket_depth [256];
  int        dir_depth;
  int        buckets_used;
  int        capacity;
  int        errors;
  outcome_t  pending [$];

  function new();
    for (int i = 0; i < 256; i++) begin
      dir_map[i] = 0;
      bucket_depth[i] = 0;
    end
    for (int i = 0; i < 1024; i++) slot_used[i] = 0;
    dir_depth = 0;
    buckets_used = 1;
    capacity = 4;
    errors = 0;
  endfunction

  function void set_capacity(bit [2:0] c);
    capacity = c;
  endfunction

  function int bucket_of(bit [31:0] k);
    int idx;
    idx = k & ((1 << dir_depth) - 1);
    return dir_map[idx & 255];
  endfunction

  function int slot_of(int b, bit [31:0] k);
    for (int s = 0; s < 4; s++)
      if (slot_used[b * 4 + s] && slot_key[b * 4 + s] == k) return b * 4 + s;
    return -1;
  endfunction

  function bit split(int b);
    int ld, nb, n, dst, src;
    ld = bucket_depth[b];
    if (ld >= dir_depth) begin
      if (dir_depth >= 8) return 0;
      n = 1 << dir_depth;
      for (int i = 0; i < n; i++) dir_map[n + i] = dir_map[i];
      dir_depth++;
    end
    if (buckets_used >= 256) return 0;
    nb = buckets_used;
    buckets_used++;
    bucket_depth[b] = ld + 1;
    bucket_depth[nb] = ld + 1;
    n = 1 << dir_depth;
    for (int i = 0; i < n; i++)
      if (dir_map[i] == b && ((i >> ld) & 1)) dir_map[i] = nb;
    dst = 0;
    for (int s = 0; s < 4; s++) begin
      src = b * 4 + s;
      if (slot_used[src] && slot_key[src][ld]) begin
        slot_key[nb * 4 + dst] = slot_key[src];
        slot_val[nb * 4 + dst] = slot_val[src];
        slot_used[nb * 4 + dst] = 1;
        slot_used[src] = 0;
        dst++;
      end
    end
    return 1;
  endfunction

  function bit store(bit [31:0] k, bit [31:0] v);
    int b, hit, cnt, free_i, cap;
    bit have_free;
    cap = (capacity < 1) ? 1 : (capacity > 4) ? 4 : capacity;
    for (int t = 0; t < 20; t++) begin
      b = bucket_of(k);
      hit = slot_of(b, k);
      if (hit >= 0) begin
        slot_val[hit] = v;
        return 0;
      end
      cnt = 0;
      have_free = 0;
      free_i = 0;
      for (int s = 0; s < 4; s++) begin
        if (slot_used[b * 4 + s]) cnt++;
        else if (!have_free) begin
          have_free = 1;
          free_i = b * 4 + s;
        end
      end
      if (cnt < cap && have_free) begin
        slot_key[free_i] = k;
        slot_val[free_i] = v;
        slot_used[free_i] = 1;
        return 0;
      end
      if (!split(b)) return 1;
    end
    return 1;
  endfunction

  function void note_input(logic [1:0] op, bit [31:0] k, bit [31:0] v);
    outcome_t o;
    int hit;
    o.found = 0;
    o.read_value = 0;
    o.status = 0;
    case (op)
      ehash_pkg::OP_FIND: begin
        hit = slot_of(bucket_of(k), k);
        if (hit >= 0) begin
          o.found = 1;
          o.read_value = slot_val[hit];
        end
      end
      ehash_pkg::OP_INSERT: o.status = store(k, v);
      ehash_pkg::OP_REMOVE: begin
        hit = slot_of(bucket_of(k), k);
        if (hit >= 0) begin
          o.found = 1;
          slot_used[hit] = 0;
        end
      end
      default: ;
    endcase
    o.key_local_depth = bucket_depth[bucket_of(k)];
    o.current_global_depth = dir_depth;
    o.bucket_count = buckets_used;
    pending.insert(pending.size(), o);
  endfunction

  function void check_result(outcome_t got);
    outcome_t want;
    if (pending.size() == 0) begin
      $error("result beat with no expectation waiting");
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.found !== want.found) begin
      $error("found: expected %0d, actual %0d", want.found, got.found);
      errors++;
    end
    if (got.read_value !== want.read_value) begin
      $error("read_value: expected %0h, actual %0h", want.read_value, got.read_value);
      errors++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      errors++;
    end
    if (got.key_local_depth !== want.key_local_depth) begin
      $error("key_local_depth: expected %0d, actual %0d",
             want.key_local_depth, got.key_local_depth);
      errors++;
    end
    if (got.current_global_depth !== want.current_global_depth) begin
      $error("current_global_depth: expected %0d, actual %0d",
             want.current_global_depth, got.current_global_depth);
      errors++;
    end
    if (got.bucket_count !== want.bucket_count) begin
      $error("bucket_count: expected %0d, actual %0d", want.bucket_count, got.bucket_count);
      errors++;
    end
  endfunction
endclass

module testbench;
  import ehash_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  logic               busy;
  logic [1:0]         op = OP_FIND;
  logic [KEY_W-1:0]   key = 0;
  logic [VAL_W-1:0]   value = 0;
  logic               bucket_capacity_we = 0;
  logic [CAP_W-1:0]   bucket_capacity = 0;
  logic               done;
  logic               found;
  logic [VAL_W-1:0]   read_value;
  logic               status;
  logic [DEPTH_W-1:0] key_local_depth;
  logic [DEPTH_W-1:0] current_global_depth;
  logic [CNT_W-1:0]   bucket_count;

  hash_table_scoreboard table_model = new();
  bit [31:0] used_keys [$];
  int cycles = 0;

  extendible_hash_table_unit dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    outcome_t got;
    if (!rst && done) begin
      got.found = found;
      got.read_value = read_value;
      got.status = status;
      got.key_local_depth = key_local_depth;
      got.current_global_depth = current_global_depth;
      got.bucket_count = bucket_count;
      table_model.check_result(got);
    end
  end

  task automatic issue(logic [1:0] o, bit [31:0] k, bit [31:0] v);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    op <= o;
    key <= k;
    value <= v;
    do @(posedge clk); while (busy);
    table_model.note_input(o, k, v);
    used_keys.insert(used_keys.size(), k);
  endtask

  task automatic drain();
    start <= 0;
    while (table_model.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_capacity(bit [2:0] c);
    bucket_capacity_we <= 1;
    bucket_capacity <= c;
    @(posedge clk);
    bucket_capacity_we <= 0;
    table_model.set_capacity(c);
  endtask

  function automatic bit [31:0] pick_key();
    bit [31:0] k;
    if (used_keys.size() != 0 && $urandom_range(0, 9) < 6)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    k = $urandom();
    if ($urandom_range(0, 1)) k[7:0] = k[7:0] & ($urandom_range(0, 1) ? 8'h0f : 8'h03);
    return k;
  endfunction

  task automatic random_items(int count);
    int r;
    logic [1:0] o;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      o = (r < 45) ? OP_INSERT : (r < 75) ? OP_FIND : (r < 95) ? OP_REMOVE : 2'd3;
      issue(o, pick_key(), $urandom());
    end
  endtask

  initial begin
    bit [2:0] caps [6] = '{3'd4, 3'd1, 3'd2, 3'd0, 3'd7, 3'd3};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_capacity(3'd4);

    issue(OP_FIND, 32'h0, 32'h0);
    issue(OP_REMOVE, 32'hffff_ffff, 32'h0);
    issue(OP_INSERT, 32'h0, 32'hffff_ffff);
    issue(OP_INSERT, 32'hffff_ffff, 32'h0);
    issue(OP_FIND, 32'h0, 32'h0);
    issue(OP_FIND, 32'hffff_ffff, 32'hffff_ffff);
    issue(OP_INSERT, 32'h0, 32'h1234_5678);
    issue(OP_FIND, 32'h0, 32'h0);
    issue(2'd3, 32'h0, 32'hffff_ffff);
    for (int i = 1; i <= 4; i++) issue(OP_INSERT, i * 2, i);
    issue(OP_REMOVE, 32'h2, 32'h0);
    issue(OP_REMOVE, 32'h2, 32'h0);
    issue(OP_FIND, 32'h4, 32'h0);
    drain();
    // Keys that agree in all eight directory bits drive one bucket to full depth.
    write_capacity(3'd1);
    issue(OP_INSERT, 32'h0000_0155, 32'haaaa_5555);
    issue(OP_INSERT, 32'h0000_0255, 32'h5555_aaaa);
    issue(OP_INSERT, 32'h0000_0355, 32'h0f0f_f0f0);
    issue(OP_FIND, 32'h0000_0255, 32'h0);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_capacity(caps[p]);
      random_items(155);
      drain();
    end

    if (table_model.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

// File: sim.f
src/ehash_pkg.sv
src/ehash_store.sv
src/extendible_hash_table_unit.sv
tb/sv/testbench.sv
